FILE: rtl/rnc_pkg.sv
// ----------------------------------------------------------------------------
// rnc_pkg
// shared types and codes of the radix node16 child table
// ----------------------------------------------------------------------------
package rnc_pkg;

  // function codes
  localparam logic [3:0] FN_INSERT   = 4'd0;
  localparam logic [3:0] FN_CHANGE   = 4'd1;
  localparam logic [3:0] FN_REMOVE   = 4'd2;
  localparam logic [3:0] FN_LOOKUP   = 4'd3;
  localparam logic [3:0] FN_RANGE    = 4'd4;
  localparam logic [3:0] FN_SMALLEST = 4'd5;
  localparam logic [3:0] FN_LARGEST  = 4'd6;
  localparam logic [3:0] FN_ANY      = 4'd7;
  localparam logic [3:0] FN_ANY_REV  = 4'd8;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_FLOOR   = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  // register index of remove_floor
  localparam logic REG_REMOVE_FLOOR = 1'b0;

  localparam logic [4:0] REMOVE_FLOOR_RESET = 5'd3;
  localparam int LEAF_BIT    = 63;
  localparam int MAX_RESULTS = 16;
  localparam int NW          = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [3:0]  func;
    logic [7:0]  key;
    logic [7:0]  key_high;
    logic [63:0] child_value;
    logic        force_req;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  key_out;
    logic [63:0] child_out;
    logic        last;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic issue;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_more;
    logic rd_busy;
    logic out_free;
    logic range_again;
  } sts_t;

endpackage

FILE: rtl/radix_node16_child_table.sv
// ----------------------------------------------------------------------------
// radix_node16_child_table
// sixteen-slot radix tree node child table with insert, change, remove,
// lookup, sorted range list, smallest/largest in range and any-child queries
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload          direction
//  -------   -----------------------   --------------   ---------
//  req       req_valid / req_stall     rnc_pkg::req_t   in
//  rsp       rsp_valid / rsp_stall     rnc_pkg::rsp_t   out
//  apb       psel / penable / pready   remove_floor     config
//
//  one transaction at a time; each pass reads the used slots one per cycle
//  through a single registered memory port (nothing is read for an insert);
//  the result register loads once the last read data has landed and the
//  output register is free, and the next request can be taken in the cycle
//  after the final result loads; range list runs one pass per result plus
//  a final one, each result leaving as the next pass ends
//  req_stall is high from acceptance until the last result is in the output
//  register; the output register keeps holding while rsp_stall is high
//  rst clears counts and control; slot contents need no clearing pass since
//  only slots below the used count are ever read
//
module radix_node16_child_table #(
  parameter int SLOTS = 16
) (
  input  logic          clk,
  input  logic          rst,
  // request channel
  input  logic          req_valid,
  output logic          req_stall,
  input  rnc_pkg::req_t req,
  // result channel
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rnc_pkg::rsp_t rsp,
  // configuration port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import rnc_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic [4:0] remove_floor;

  // apb register: remove_floor at byte address 0
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      remove_floor <= REMOVE_FLOOR_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_REMOVE_FLOOR)) begin
      remove_floor <= pwdata[4:0];
    end
  end

  // read data, zero beyond the register list
  always_comb begin
    if (paddr[2] == REG_REMOVE_FLOOR) begin
      prdata = {27'd0, remove_floor};
    end else begin
      prdata = 32'd0;
    end
  end

  // sequencer
  rnc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // slot storage, compare and result register
  rnc_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .req          (req),
    .remove_floor (remove_floor),
    .rsp          (rsp),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall)
  );

endmodule

FILE: rtl/rnc_ctrl.sv
// ----------------------------------------------------------------------------
// rnc_ctrl
// sequencer: accept, slot scan, commit of one transaction at a time
// ----------------------------------------------------------------------------
module rnc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  rnc_pkg::sts_t sts,
  output rnc_pkg::cmd_t cmd
);
  import rnc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;

  always_comb begin
    cmd        = '0;
    cmd.load   = (state == S_IDLE) && req_valid;
    cmd.issue  = (state == S_SCAN) && sts.scan_more;
    cmd.commit = (state == S_FINISH) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      req_stall <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state     <= S_SCAN;
            req_stall <= 1'b1;
          end
        end
        S_SCAN: begin
          // last read data has landed
          if (!sts.scan_more && !sts.rd_busy) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (sts.out_free) begin
            if (sts.range_again) begin
              state <= S_SCAN;
            end else begin
              state     <= S_IDLE;
              req_stall <= 1'b0;
            end
          end
        end
        default: begin
          state     <= S_IDLE;
          req_stall <= 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: rtl/rnc_dp.sv
// ----------------------------------------------------------------------------
// rnc_dp
// slot memories, scan compare, selection registers and result register
// ----------------------------------------------------------------------------
module rnc_dp #(
  parameter int SLOTS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  rnc_pkg::cmd_t cmd,
  output rnc_pkg::sts_t sts,
  input  rnc_pkg::req_t req,
  input  logic [4:0]    remove_floor,
  output rnc_pkg::rsp_t rsp,
  output logic          rsp_valid,
  input  logic          rsp_stall
);
  import rnc_pkg::*;

  localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNTW = $clog2(SLOTS + 1);
  localparam int CMPW = (CNTW > 5) ? CNTW : 5;

  logic [7:0]  key_mem   [SLOTS];
  logic [63:0] child_mem [SLOTS];

  req_t            op;
  logic [CNTW-1:0] used, live, cnt, scan_len;
  logic [IDXW-1:0] rd_addr, rd_idx, sel_idx, prev_idx;
  logic            rd_vld;
  logic [7:0]      rd_key, sel_key, prev_key;
  logic [63:0]     rd_child, sel_child, pend_child;
  logic [7:0]      pend_key;
  logic            found, leaf_found, take;
  logic [NW-1:0]   n_found;

  // commit decode
  logic            out_load, restart;
  rsp_t            res;
  logic            we_key, we_child;
  logic [IDXW-1:0] w_addr;
  logic [63:0]     w_child;
  logic            inc_counts, dec_live, range_found_step;

  always_comb begin
    if (op.func >= FN_CHANGE && op.func <= FN_ANY_REV) begin
      scan_len = used;
    end else begin
      scan_len = '0;
    end
  end

  always_comb begin
    if (op.func == FN_ANY_REV) begin
      rd_addr = IDXW'(used - CNTW'(1) - cnt);
    end else begin
      rd_addr = cnt[IDXW-1:0];
    end
  end

  // per-slot candidate test on the returned read data
  always_comb begin
    logic rd_live, in_lo, in_hi, after;
    rd_live = (rd_child != 64'd0);
    in_lo   = (rd_key >= op.key);
    in_hi   = (rd_key <= op.key_high);
    after   = (n_found == '0) || (rd_key > prev_key) ||
              ((rd_key == prev_key) && (rd_idx > prev_idx));
    case (op.func)
      FN_CHANGE, FN_REMOVE, FN_LOOKUP: take = rd_live && (rd_key == op.key) && !found;
      FN_RANGE:    take = rd_live && in_lo && in_hi && after &&
                          (!found || (rd_key < sel_key));
      FN_SMALLEST: take = rd_live && in_lo && (!found || (rd_key <= sel_key));
      FN_LARGEST:  take = rd_live && in_hi && (!found || (rd_key >= sel_key));
      FN_ANY, FN_ANY_REV: take = rd_live && !leaf_found;
      default:     take = 1'b0;
    endcase
  end

  assign range_found_step = (op.func == FN_RANGE) && found &&
                            (n_found != NW'(MAX_RESULTS));

  always_comb begin
    out_load      = 1'b1;
    restart       = 1'b0;
    res.status    = ST_OK;
    res.key_out   = op.key;
    res.child_out = 64'd0;
    res.last      = 1'b1;
    we_key        = 1'b0;
    we_child      = 1'b0;
    w_addr        = sel_idx;
    w_child       = op.child_value;
    inc_counts    = 1'b0;
    dec_live      = 1'b0;
    case (op.func)
      FN_INSERT: begin
        w_addr = used[IDXW-1:0];
        if (used >= CNTW'(SLOTS)) begin
          res.status = ST_FULL;
        end else begin
          we_key     = 1'b1;
          we_child   = 1'b1;
          inc_counts = 1'b1;
        end
      end
      FN_CHANGE: begin
        if (!found) begin
          res.status = ST_MISSING;
        end else begin
          we_child = 1'b1;
        end
      end
      FN_REMOVE: begin
        w_child = 64'd0;
        if ((CMPW'(live) == CMPW'(remove_floor)) && !op.force_req) begin
          res.status = ST_FLOOR;
        end else if (!found) begin
          res.status = ST_MISSING;
        end else begin
          we_child = 1'b1;
          dec_live = (live != '0);
        end
      end
      FN_LOOKUP: begin
        if (found) begin
          res.child_out = sel_child;
        end else begin
          res.status  = ST_MISSING;
          res.key_out = 8'd0;
        end
      end
      FN_RANGE: begin
        if (range_found_step) begin
          // hold the new candidate, release the previous one
          restart       = 1'b1;
          out_load      = (n_found != '0);
          res.key_out   = pend_key;
          res.child_out = pend_child;
          res.last      = 1'b0;
        end else if (n_found != '0) begin
          // nothing further in range, or the list is at its cap
          res.key_out   = pend_key;
          res.child_out = pend_child;
        end else begin
          res.status  = ST_MISSING;
          res.key_out = 8'd0;
        end
      end
      FN_SMALLEST, FN_LARGEST, FN_ANY, FN_ANY_REV: begin
        if (found) begin
          res.key_out   = sel_key;
          res.child_out = sel_child;
        end else begin
          res.status  = ST_MISSING;
          res.key_out = 8'd0;
        end
      end
      default: out_load = 1'b0;
    endcase
  end

  // slot memories
  always_ff @(posedge clk) begin
    if (cmd.commit && we_key) begin
      key_mem[w_addr] <= op.key;
    end
    if (cmd.commit && we_child) begin
      child_mem[w_addr] <= w_child;
    end
    if (cmd.issue) begin
      rd_key   <= key_mem[rd_addr];
      rd_child <= child_mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= '0;
      live       <= '0;
      cnt        <= '0;
      rd_vld     <= 1'b0;
      found      <= 1'b0;
      leaf_found <= 1'b0;
      n_found    <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      rd_vld <= cmd.issue;
      if (cmd.load) begin
        cnt        <= '0;
        found      <= 1'b0;
        leaf_found <= 1'b0;
        n_found    <= '0;
      end else if (cmd.commit && restart) begin
        cnt     <= '0;
        found   <= 1'b0;
        n_found <= NW'(n_found + NW'(1));
      end else begin
        if (cmd.issue) begin
          cnt <= CNTW'(cnt + CNTW'(1));
        end
        if (rd_vld && take) begin
          found      <= 1'b1;
          leaf_found <= rd_child[LEAF_BIT];
        end
      end
      if (cmd.commit && inc_counts) begin
        used <= CNTW'(used + CNTW'(1));
        live <= CNTW'(live + CNTW'(1));
      end else if (cmd.commit && dec_live) begin
        live <= CNTW'(live - CNTW'(1));
      end
      if (cmd.commit && out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= req;
    end
    if (cmd.issue) begin
      rd_idx <= rd_addr;
    end
    if (rd_vld && take) begin
      sel_idx   <= rd_idx;
      sel_key   <= rd_key;
      sel_child <= rd_child;
    end
    if (cmd.commit && restart) begin
      pend_key   <= sel_key;
      pend_child <= sel_child;
      prev_key   <= sel_key;
      prev_idx   <= sel_idx;
    end
    if (cmd.commit && out_load) begin
      rsp <= res;
    end
  end

  always_comb begin
    sts             = '0;
    sts.scan_more   = (cnt < scan_len);
    sts.rd_busy     = rd_vld;
    sts.out_free    = !rsp_valid || !rsp_stall;
    sts.range_again = range_found_step;
  end

endmodule

FILE: sim/radix_node16_child_table_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_node16_child_table_check
// watches the request, result and config transactions, keeps a shadow copy
// of the node table and compares every result transaction field by field
// ----------------------------------------------------------------------------
module radix_node16_child_table_check #(
  parameter int SLOTS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  rnc_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  rnc_pkg::rsp_t rsp,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic          pready,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output int            fail_count,
  output int            pending,
  output int            results_seen
);
  import rnc_pkg::*;

  localparam logic [2:0] FLOOR_ADDR = {REG_REMOVE_FLOOR, 2'b00};
  localparam int MAX_REPORTS = 10;

  // shadow node table
  logic [7:0]  slot_key   [SLOTS];
  logic [63:0] slot_child [SLOTS];
  int          used_n = 0;
  int          live_n = 0;
  logic [4:0]  floor_val = REMOVE_FLOOR_RESET;

  // results still owed by the block, oldest first
  rsp_t node_results_q [$];
  int   err_n = 0;
  int   rsp_n = 0;

  function automatic rsp_t mk_rsp(input logic [1:0] st, input logic [7:0] k,
                                  input logic [63:0] c, input logic l);
    rsp_t v;
    v.status    = st;
    v.key_out   = k;
    v.child_out = c;
    v.last      = l;
    return v;
  endfunction

  // lowest used slot with this key and a live child, -1 if none
  function automatic int live_slot(input logic [7:0] k);
    for (int i = 0; i < used_n; i++) begin
      if (slot_key[i] == k && slot_child[i] != 64'd0) return i;
    end
    return -1;
  endfunction

  task automatic run_node_op(input req_t r);
    int         pos;
    int         sel;
    int         n;
    int         j;
    int         i;
    int         emit_n;
    int         idx [SLOTS];
    logic [7:0] best;
    logic       hit;
    logic       leaf_found;
    case (r.func)
      FN_INSERT: begin
        if (used_n >= SLOTS) begin
          node_results_q.push_back(mk_rsp(ST_FULL, r.key, 64'd0, 1'b1));
        end else begin
          slot_key[used_n]   = r.key;
          slot_child[used_n] = r.child_value;
          used_n++;
          live_n++;
          node_results_q.push_back(mk_rsp(ST_OK, r.key, 64'd0, 1'b1));
        end
      end
      FN_CHANGE: begin
        pos = live_slot(r.key);
        if (pos < 0) begin
          node_results_q.push_back(mk_rsp(ST_MISSING, r.key, 64'd0, 1'b1));
        end else begin
          slot_child[pos] = r.child_value;
          node_results_q.push_back(mk_rsp(ST_OK, r.key, 64'd0, 1'b1));
        end
      end
      FN_REMOVE: begin
        pos = live_slot(r.key);
        if (live_n == int'(floor_val) && !r.force_req) begin
          node_results_q.push_back(mk_rsp(ST_FLOOR, r.key, 64'd0, 1'b1));
        end else if (pos < 0) begin
          node_results_q.push_back(mk_rsp(ST_MISSING, r.key, 64'd0, 1'b1));
        end else begin
          slot_child[pos] = 64'd0;
          if (live_n > 0) live_n--;
          node_results_q.push_back(mk_rsp(ST_OK, r.key, 64'd0, 1'b1));
        end
      end
      FN_LOOKUP: begin
        pos = live_slot(r.key);
        if (pos < 0) begin
          node_results_q.push_back(mk_rsp(ST_MISSING, 8'd0, 64'd0, 1'b1));
        end else begin
          node_results_q.push_back(mk_rsp(ST_OK, r.key, slot_child[pos], 1'b1));
        end
      end
      FN_RANGE: begin
        // stable insertion sort by key
        n = 0;
        for (i = 0; i < used_n; i++) begin
          if (slot_child[i] != 64'd0 && slot_key[i] >= r.key && slot_key[i] <= r.key_high) begin
            j = n;
            while (j > 0 && slot_key[idx[j-1]] > slot_key[i]) begin
              idx[j] = idx[j-1];
              j--;
            end
            idx[j] = i;
            n++;
          end
        end
        if (n == 0) begin
          node_results_q.push_back(mk_rsp(ST_MISSING, 8'd0, 64'd0, 1'b1));
        end else begin
          emit_n = (n < MAX_RESULTS) ? n : MAX_RESULTS;
          for (j = 0; j < emit_n; j++) begin
            node_results_q.push_back(mk_rsp(ST_OK, slot_key[idx[j]], slot_child[idx[j]],
                                            j + 1 == emit_n));
          end
        end
      end
      FN_SMALLEST, FN_LARGEST: begin
        best = (r.func == FN_SMALLEST) ? 8'hFF : 8'h00;
        sel  = -1;
        for (i = 0; i < used_n; i++) begin
          hit = (r.func == FN_SMALLEST) ? (slot_key[i] >= r.key && slot_key[i] <= best)
                                        : (slot_key[i] <= r.key_high && slot_key[i] >= best);
          if (hit && slot_child[i] != 64'd0) begin
            best = slot_key[i];
            sel  = i;
          end
        end
        if (sel < 0) begin
          node_results_q.push_back(mk_rsp(ST_MISSING, 8'd0, 64'd0, 1'b1));
        end else begin
          node_results_q.push_back(mk_rsp(ST_OK, slot_key[sel], slot_child[sel], 1'b1));
        end
      end
      FN_ANY, FN_ANY_REV: begin
        sel        = -1;
        leaf_found = 1'b0;
        for (int s = 0; s < used_n && !leaf_found; s++) begin
          i = (r.func == FN_ANY) ? s : used_n - 1 - s;
          if (slot_child[i] != 64'd0) begin
            sel        = i;
            leaf_found = slot_child[i][LEAF_BIT];
          end
        end
        if (sel < 0) begin
          node_results_q.push_back(mk_rsp(ST_MISSING, 8'd0, 64'd0, 1'b1));
        end else begin
          node_results_q.push_back(mk_rsp(ST_OK, slot_key[sel], slot_child[sel], 1'b1));
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_result(input rsp_t got);
    rsp_t want;
    if (node_results_q.size() == 0) begin
      err_n++;
      if (err_n <= MAX_REPORTS)
        $display("unexpected result: status %0d key %h child %h last %b",
                 got.status, got.key_out, got.child_out, got.last);
    end else begin
      want = node_results_q.pop_front();
      if (got.status !== want.status || got.key_out !== want.key_out ||
          got.child_out !== want.child_out || got.last !== want.last) begin
        err_n++;
        if (err_n <= MAX_REPORTS)
          $display("result mismatch: expected status %0d key %h child %h last %b, got status %0d key %h child %h last %b",
                   want.status, want.key_out, want.child_out, want.last,
                   got.status, got.key_out, got.child_out, got.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      used_n    = 0;
      live_n    = 0;
      floor_val = REMOVE_FLOOR_RESET;
      node_results_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == FLOOR_ADDR) floor_val = pwdata[4:0];
      if (rsp_valid && !rsp_stall) begin
        rsp_n++;
        check_result(rsp);
      end
      if (req_valid && !req_stall) run_node_op(req);
    end
    fail_count   <= err_n;
    pending      <= node_results_q.size();
    results_seen <= rsp_n;
  end

endmodule

FILE: sim/radix_node16_child_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_node16_child_table_test
// drives the node table with a directed opening and three random phases
// under different stall mixes and floor settings; the checker beside the
// block predicts and compares, this module gives the verdict
// ----------------------------------------------------------------------------
module radix_node16_child_table_test;
  import rnc_pkg::*;

  localparam int PHASE_ITEMS  = 51;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 400000;

  // codes the block ignores
  localparam logic [3:0] FN_FIRST_UNUSED = 4'd9;
  localparam logic [3:0] FN_LAST_UNUSED  = 4'd15;

  localparam logic [2:0] FLOOR_ADDR = {REG_REMOVE_FLOOR, 2'b00};

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req       = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int results_seen;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_n       = 0;
  int items_sent    = 0;

  // keys inserted so far, reused to hit live entries and duplicates
  logic [7:0] key_pool [$];

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  radix_node16_child_table u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  radix_node16_child_table_check u_check (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .rsp          (rsp),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  // receiver side: stall is drawn fresh every cycle
  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_n, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic req_t mk_item(input logic [3:0] fn, input logic [7:0] k,
                                   input logic [7:0] khi, input logic [63:0] c,
                                   input logic frc);
    req_t r;
    r.func        = fn;
    r.key         = k;
    r.key_high    = khi;
    r.child_value = c;
    r.force_req   = frc;
    return r;
  endfunction

  // mostly keys already in the table, sometimes anything
  function automatic logic [7:0] pick_key();
    if (key_pool.size() > 0 && $urandom_range(3) != 0)
      return key_pool[$urandom_range(key_pool.size() - 1)];
    return 8'($urandom_range(255));
  endfunction

  // random handle, leaf bit half the time, now and then the empty handle
  function automatic logic [63:0] pick_child();
    logic [63:0] v;
    v = {$urandom, $urandom};
    if ($urandom_range(19) == 0) v = 64'd0;
    return v;
  endfunction

  function automatic req_t rand_item();
    req_t       r;
    int         pick;
    logic [7:0] a;
    logic [7:0] b;
    pick          = $urandom_range(99);
    r.key         = pick_key();
    r.key_high    = 8'($urandom_range(255));
    r.child_value = pick_child();
    r.force_req   = 1'($urandom_range(1));
    if (pick < 20)      r.func = FN_INSERT;
    else if (pick < 32) r.func = FN_CHANGE;
    else if (pick < 46) r.func = FN_REMOVE;
    else if (pick < 58) r.func = FN_LOOKUP;
    else if (pick < 74) r.func = FN_RANGE;
    else if (pick < 80) r.func = FN_SMALLEST;
    else if (pick < 86) r.func = FN_LARGEST;
    else if (pick < 91) r.func = FN_ANY;
    else if (pick < 96) r.func = FN_ANY_REV;
    else                r.func = 4'($urandom_range(FN_FIRST_UNUSED, FN_LAST_UNUSED));
    if (r.func == FN_RANGE) begin
      a = pick_key();
      b = pick_key();
      pick = $urandom_range(99);
      if (pick < 20) begin
        // whole key space, the long sorted lists
        r.key      = 8'h00;
        r.key_high = 8'hFF;
      end else if (pick < 35) begin
        // bounds swapped: empty range unless they are equal
        r.key      = (a > b) ? a : b;
        r.key_high = (a > b) ? b : a;
      end else begin
        r.key      = (a < b) ? a : b;
        r.key_high = (a < b) ? b : a;
      end
    end else if (r.func == FN_LARGEST) begin
      r.key_high = pick_key();
    end
    return r;
  endfunction

  // one request transaction; valid stays high into the next call when no gap
  task automatic send_item(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    items_sent++;
    if (r.func == FN_INSERT) key_pool.push_back(r.key);
  endtask

  // apb write of the floor register: setup then access
  task automatic write_floor(input logic [4:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FLOOR_ADDR;
    pwdata  <= {27'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // all results in, block released, then a margin for ignored requests
  task automatic wait_idle();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0 || req_stall);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int snd_pct, input int rcv_pct, input logic [4:0] floor_v);
    send_idle_pct <= snd_pct;
    recv_idle_pct <= rcv_pct;
    write_floor(floor_v);
    repeat (PHASE_ITEMS) send_item(rand_item());
    wait_idle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // floor of zero so that an unforced removal on the empty table is refused
    write_floor(5'd0);

    // queries on the empty table
    send_item(mk_item(FN_LOOKUP,   8'h00, 8'h00, 64'd0, 1'b0));
    send_item(mk_item(FN_RANGE,    8'h00, 8'hFF, 64'd0, 1'b0));
    send_item(mk_item(FN_SMALLEST, 8'h00, 8'hFF, 64'd0, 1'b0));
    send_item(mk_item(FN_LARGEST,  8'h00, 8'hFF, 64'd0, 1'b0));
    send_item(mk_item(FN_ANY,      8'h00, 8'h00, 64'd0, 1'b0));
    send_item(mk_item(FN_ANY_REV,  8'hFF, 8'hFF, 64'd0, 1'b0));
    // change of an absent key, removal at the floor, forced removal of an absent key
    send_item(mk_item(FN_CHANGE,   8'h10, 8'h00, 64'd5, 1'b0));
    send_item(mk_item(FN_REMOVE,   8'h10, 8'h00, 64'd0, 1'b0));
    send_item(mk_item(FN_REMOVE,   8'h10, 8'h00, 64'd0, 1'b1));
    // no leaves yet: zero handle insert counts as live, duplicate keys
    send_item(mk_item(FN_INSERT,   8'hFF, 8'h00, 64'd1, 1'b0));
    send_item(mk_item(FN_INSERT,   8'h40, 8'h00, 64'd0, 1'b0));
    send_item(mk_item(FN_INSERT,   8'h40, 8'h00, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0));
    // any falls back to highest live slot, any reverse to lowest
    send_item(mk_item(FN_ANY,      8'h00, 8'h00, 64'd0, 1'b0));
    send_item(mk_item(FN_ANY_REV,  8'h00, 8'h00, 64'd0, 1'b0));
    // leaves, one of them a further duplicate
    send_item(mk_item(FN_INSERT,   8'h00, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0));
    send_item(mk_item(FN_INSERT,   8'h40, 8'h00, 64'h8000_0000_0000_0000, 1'b0));
    // lowest live duplicate, equal keys in slot order, empty and full ranges
    send_item(mk_item(FN_LOOKUP,   8'h40, 8'h00, 64'd0, 1'b0));
    send_item(mk_item(FN_RANGE,    8'h40, 8'h40, 64'd0, 1'b0));
    send_item(mk_item(FN_RANGE,    8'h80, 8'h10, 64'd0, 1'b0));
    send_item(mk_item(FN_RANGE,    8'h00, 8'hFF, 64'd0, 1'b0));
    // smallest and largest take the highest slot among equal keys
    send_item(mk_item(FN_SMALLEST, 8'h01, 8'h00, 64'd0, 1'b0));
    send_item(mk_item(FN_LARGEST,  8'h00, 8'hFE, 64'd0, 1'b0));
    // leaf preferred from either end
    send_item(mk_item(FN_ANY,      8'h00, 8'h00, 64'd0, 1'b0));
    send_item(mk_item(FN_ANY_REV,  8'h00, 8'h00, 64'd0, 1'b0));
    // change to the empty handle, plain removal, ignored code
    send_item(mk_item(FN_CHANGE,   8'h40, 8'h00, 64'd0, 1'b0));
    send_item(mk_item(FN_REMOVE,   8'hFF, 8'h00, 64'd0, 1'b0));
    send_item(mk_item(FN_LAST_UNUSED, 8'h00, 8'h00, 64'd0, 1'b0));
    wait_idle();

    // random phases: eager sender with busy receiver, the reverse, then full rate
    run_phase(17, 75, 5'd16);
    run_phase(75, 17, 5'($urandom_range(2, 8)));
    run_phase(0, 0, 5'd31);

    $display("covered %0d request and %0d result transactions", items_sent, results_seen);
    $display("floor settings 0, 16, mid and 31 under three stall mixes, table filled past full");
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", fail_count, pending);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
